// ===== hdl/segment_obstacle_visibility_test_macros.svh =====
// Assertion macros shared by the checker files of the visibility test block.
// Depends on nothing; expects signals clk and rst_n in the scope of use.
`ifndef SEGMENT_OBSTACLE_VISIBILITY_TEST_MACROS_SVH
`define SEGMENT_OBSTACLE_VISIBILITY_TEST_MACROS_SVH

// Implication into the next cycle, off while reset is low.
`define SOVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication, off while reset is low.
`define SOVT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset.
`define SOVT_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sovt_pkg.sv =====
// Shared types and constants of the segment obstacle visibility test.
// No dependencies.
package sovt_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int COORD_BITS   = 9;
  localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
  localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int PROD_BITS    = 2 * DIFF_BITS;
  localparam int NUM_PRODS    = 8;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_QUERY = 2'd2
  } req_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } point_t;

  typedef struct packed {
    point_t pt;
    logic   closes;
  } vertex_t;

endpackage

// ===== hdl/segment_obstacle_visibility_test.sv =====
// Top level of the segment obstacle visibility test: vertex store, edge walk and
// the orientation datapath. Depends on sovt_pkg.

// A word is accepted when start is high and busy is low; each accepted word gives
// exactly one result word on the out_ ports, shown for one cycle with out_valid,
// and the receiver cannot stall it. A load or clear word answers in the next
// cycle and busy stays low, so these can be issued every cycle. A query raises
// busy and walks the closed polygons out of the vertex memory, one vertex read
// per cycle except at a closing vertex, where the next read waits for the wrap
// edge of its polygon; its result word comes out once the walk and the orientation
// stages have drained. The memory is not cleared at reset: only entries below
// the vertex count are ever read, so no clearing pass is needed.
module segment_obstacle_visibility_test (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_req_type,
  input  logic [sovt_pkg::COORD_BITS-1:0]   in_ax,
  input  logic [sovt_pkg::COORD_BITS-1:0]   in_ay,
  input  logic [sovt_pkg::COORD_BITS-1:0]   in_bx,
  input  logic [sovt_pkg::COORD_BITS-1:0]   in_by,
  input  logic                              in_closes_polygon,
  output logic                              out_valid,
  output logic                              out_blocked,
  output logic                              out_status,
  output logic [sovt_pkg::CNT_BITS-1:0]     out_stored_vertices
);

  localparam logic [sovt_pkg::CNT_BITS-1:0] CNT_FULL =
    sovt_pkg::CNT_BITS'(sovt_pkg::MAX_VERTICES);

  // Control state
  sovt_pkg::state_t                 state_r, state_nxt;
  logic [sovt_pkg::CNT_BITS-1:0]    count_r;      // vertices held
  logic [sovt_pkg::CNT_BITS-1:0]    open_start_r; // first vertex of the open polygon
  logic [sovt_pkg::CNT_BITS-1:0]    rd_addr_r;    // next address to read in the walk
  logic                             rdv_r;        // read data below is valid
  logic                             first_flag_r; // next vertex starts a polygon
  logic                             wrap_r;       // wrap edge due this cycle
  logic                             ev_r;         // edge pair below is valid
  logic                             pv_r;         // products below are valid
  logic                             blk_r;        // some edge has hit so far

  // Query segment
  sovt_pkg::point_t                 qa_r, qb_r;

  // Walk datapath
  sovt_pkg::vertex_t                rdat_r;
  sovt_pkg::point_t                 first_r, prev_r;
  sovt_pkg::point_t                 ep_r, eq_r;
  logic signed [sovt_pkg::PROD_BITS-1:0] prod_r [sovt_pkg::NUM_PRODS];

  // Output registers
  logic                             out_valid_r;
  logic                             out_blocked_r;
  logic                             out_status_r;
  logic [sovt_pkg::CNT_BITS-1:0]    out_stored_r;

  // Vertex memory
  sovt_pkg::vertex_t                mem [sovt_pkg::MAX_VERTICES];

  logic accept;
  logic is_load, is_clear, is_query;
  logic full;
  logic walking, issue, close_seen, drained, done;
  logic edge_hit;

  assign accept   = start && !busy;
  assign is_load  = in_req_type == sovt_pkg::REQ_LOAD;
  assign is_clear = in_req_type == sovt_pkg::REQ_CLEAR;
  assign is_query = in_req_type == sovt_pkg::REQ_QUERY;
  assign full     = count_r == CNT_FULL;

  // ---------------------------------------------------------------------------
  // FSM: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sovt_pkg::ST_IDLE: begin
        if (accept && is_query) state_nxt = sovt_pkg::ST_WALK;
      end
      sovt_pkg::ST_WALK: begin
        if (done) state_nxt = sovt_pkg::ST_IDLE;
      end
      default: state_nxt = sovt_pkg::ST_IDLE;
    endcase
  end

  // FSM: outputs
  // A closing vertex arriving from memory holds the read address: no read is
  // issued while it is seen, and the walk resumes as its wrap edge forms.
  always_comb begin
    walking    = state_r == sovt_pkg::ST_WALK;
    close_seen = rdv_r && rdat_r.closes;
    issue      = walking && (rd_addr_r < open_start_r) && !close_seen;
    drained    = (rd_addr_r >= open_start_r) && !rdv_r && !wrap_r && !ev_r && !pv_r;
    done       = walking && drained;
    busy       = walking;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sovt_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // ---------------------------------------------------------------------------
  // Memory: one write port for loads, one read port for the walk.
  always_ff @(posedge clk) begin
    if (accept && is_load && !full) begin
      mem[count_r[sovt_pkg::ADDR_BITS-1:0]] <= '{pt: '{x: in_ax, y: in_ay},
                                                 closes: in_closes_polygon};
    end
    if (issue) rdat_r <= mem[rd_addr_r[sovt_pkg::ADDR_BITS-1:0]];
  end

  // ---------------------------------------------------------------------------
  // Store bookkeeping and query capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      open_start_r <= '0;
    end else if (accept) begin
      unique case (in_req_type)
        sovt_pkg::REQ_LOAD: begin
          if (!full) begin
            count_r <= count_r + 1'b1;
            if (in_closes_polygon) open_start_r <= count_r + 1'b1;
          end
        end
        sovt_pkg::REQ_CLEAR: begin
          count_r      <= '0;
          open_start_r <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      qa_r <= '{x: in_ax, y: in_ay};
      qb_r <= '{x: in_bx, y: in_by};
    end
  end

  // ---------------------------------------------------------------------------
  // Edge walk: vertex i pairs with i-1 inside its polygon; the closing vertex
  // also pairs with the polygon's first vertex in the cycle after.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r    <= '0;
      rdv_r        <= 1'b0;
      first_flag_r <= 1'b1;
      wrap_r       <= 1'b0;
      ev_r         <= 1'b0;
    end else begin
      if (accept && is_query) begin
        rd_addr_r    <= '0;
        first_flag_r <= 1'b1;
      end else begin
        if (issue) rd_addr_r <= rd_addr_r + 1'b1;
        if (rdv_r) first_flag_r <= rdat_r.closes;
      end
      rdv_r  <= issue;
      wrap_r <= close_seen;
      ev_r   <= wrap_r || (rdv_r && !first_flag_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rdv_r) begin
      prev_r <= rdat_r.pt;
      if (first_flag_r) first_r <= rdat_r.pt;
    end
    if (wrap_r) begin
      ep_r <= first_r;
      eq_r <= prev_r;
    end else begin
      ep_r <= rdat_r.pt;
      eq_r <= prev_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Orientation stage 1: the eight cross-product terms
  function automatic logic signed [sovt_pkg::DIFF_BITS-1:0] sdiff(
    input logic [sovt_pkg::COORD_BITS-1:0] a,
    input logic [sovt_pkg::COORD_BITS-1:0] b
  );
    sdiff = $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  logic signed [sovt_pkg::DIFF_BITS-1:0] dabx, daby, dpax, dpay, dqax, dqay;
  logic signed [sovt_pkg::DIFF_BITS-1:0] dpqx, dpqy, dapx, dapy, dbpx, dbpy;

  always_comb begin
    dabx = sdiff(qb_r.x, qa_r.x);
    daby = sdiff(qb_r.y, qa_r.y);
    dpax = sdiff(ep_r.x, qa_r.x);
    dpay = sdiff(ep_r.y, qa_r.y);
    dqax = sdiff(eq_r.x, qa_r.x);
    dqay = sdiff(eq_r.y, qa_r.y);
    dpqx = sdiff(eq_r.x, ep_r.x);
    dpqy = sdiff(eq_r.y, ep_r.y);
    dapx = sdiff(qa_r.x, ep_r.x);
    dapy = sdiff(qa_r.y, ep_r.y);
    dbpx = sdiff(qb_r.x, ep_r.x);
    dbpy = sdiff(qb_r.y, ep_r.y);
  end

  always_ff @(posedge clk) begin
    prod_r[0] <= dabx * dpay;
    prod_r[1] <= daby * dpax;
    prod_r[2] <= dabx * dqay;
    prod_r[3] <= daby * dqax;
    prod_r[4] <= dpqx * dapy;
    prod_r[5] <= dpqy * dapx;
    prod_r[6] <= dpqx * dbpy;
    prod_r[7] <= dpqy * dbpx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pv_r <= 1'b0;
    else        pv_r <= ev_r;
  end

  // Orientation stage 2: signs and the blocking rule
  logic signed [sovt_pkg::PROD_BITS:0] o_p, o_q, o_a, o_b;
  logic neg_p, neg_q, neg_a, neg_b, pos_p, pos_q, pos_a, pos_b;

  always_comb begin
    o_p = {prod_r[0][sovt_pkg::PROD_BITS-1], prod_r[0]}
        - {prod_r[1][sovt_pkg::PROD_BITS-1], prod_r[1]};
    o_q = {prod_r[2][sovt_pkg::PROD_BITS-1], prod_r[2]}
        - {prod_r[3][sovt_pkg::PROD_BITS-1], prod_r[3]};
    o_a = {prod_r[4][sovt_pkg::PROD_BITS-1], prod_r[4]}
        - {prod_r[5][sovt_pkg::PROD_BITS-1], prod_r[5]};
    o_b = {prod_r[6][sovt_pkg::PROD_BITS-1], prod_r[6]}
        - {prod_r[7][sovt_pkg::PROD_BITS-1], prod_r[7]};
    neg_p = o_p[sovt_pkg::PROD_BITS];
    neg_q = o_q[sovt_pkg::PROD_BITS];
    neg_a = o_a[sovt_pkg::PROD_BITS];
    neg_b = o_b[sovt_pkg::PROD_BITS];
    pos_p = !neg_p && (o_p != '0);
    pos_q = !neg_q && (o_q != '0);
    pos_a = !neg_a && (o_a != '0);
    pos_b = !neg_b && (o_b != '0);
    // proper crossing, or an endpoint on the line through the query segment
    edge_hit = (((pos_p && neg_q) || (neg_p && pos_q)) &&
                ((pos_a && neg_b) || (neg_a && pos_b)))
             || (o_p == '0) || (o_q == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_r <= 1'b0;
    end else if (accept && is_query) begin
      blk_r <= 1'b0;
    end else if (pv_r && edge_hit) begin
      blk_r <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (accept && !is_query) || done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_blocked_r <= blk_r;
      out_status_r  <= 1'b0;
      out_stored_r  <= count_r;
    end else begin
      out_blocked_r <= 1'b0;
      out_status_r  <= is_load && full;
      if (is_clear)                out_stored_r <= '0;
      else if (is_load && !full)   out_stored_r <= count_r + 1'b1;
      else                         out_stored_r <= count_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_blocked         = out_blocked_r;
  assign out_status          = out_status_r;
  assign out_stored_vertices = out_stored_r;

endmodule

// ===== hdl/sovt_checker.sv =====
// Port-level checks for segment_obstacle_visibility_test, bound to the top level.
// Depends on sovt_pkg and segment_obstacle_visibility_test_macros.svh.
`include "segment_obstacle_visibility_test_macros.svh"

module sovt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic [1:0]                      in_req_type,
  input logic                            out_valid,
  input logic                            out_blocked,
  input logic                            out_status,
  input logic [sovt_pkg::CNT_BITS-1:0]   out_stored_vertices
);

  logic acc_fast, acc_clear, acc_query;

  assign acc_fast  = start && !busy && (in_req_type != sovt_pkg::REQ_QUERY);
  assign acc_clear = start && !busy && (in_req_type == sovt_pkg::REQ_CLEAR);
  assign acc_query = start && !busy && (in_req_type == sovt_pkg::REQ_QUERY);

  `SOVT_ASSERT_NEXT_ALWAYS(a_no_word_after_reset, !rst_n, !out_valid, "result word after reset")
  `SOVT_ASSERT_NEXT(a_fast_reply, acc_fast, out_valid && !busy, "load or clear word not answered")
  `SOVT_ASSERT_NEXT(a_clear_empty, acc_clear, out_stored_vertices == '0 && !out_blocked, "clear left vertices")
  `SOVT_ASSERT_NEXT(a_query_busy, acc_query, busy && !out_valid, "query did not start a walk")
  `SOVT_ASSERT_NOW(a_full_status, out_valid && out_status, out_stored_vertices == sovt_pkg::CNT_BITS'(sovt_pkg::MAX_VERTICES) && !out_blocked, "drop flagged with room left")

endmodule

bind segment_obstacle_visibility_test sovt_checker u_sovt_checker (.*);

// ===== sim/segment_obstacle_visibility_test_tb.sv =====
// Self-checking testbench for segment_obstacle_visibility_test: loads, clears and
// segment queries against a predictor of the polygon edge walk.
// Depends on sovt_pkg and the segment_obstacle_visibility_test RTL.
module segment_obstacle_visibility_test_tb;

  // Request code that the block does not define; it must answer and change nothing.
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int         COORD_MAX   = (1 << sovt_pkg::COORD_BITS) - 1;

  // One input word as the driver shows it; drain makes the driver hold it back
  // until every outstanding answer has come out.
  typedef struct {
    logic [1:0]                      req;
    logic [sovt_pkg::COORD_BITS-1:0] ax;
    logic [sovt_pkg::COORD_BITS-1:0] ay;
    logic [sovt_pkg::COORD_BITS-1:0] bx;
    logic [sovt_pkg::COORD_BITS-1:0] by;
    logic                            closes;
    bit                              drain;
  } word_t;

  typedef struct {
    logic                          blocked;
    logic                          status;
    logic [sovt_pkg::CNT_BITS-1:0] held;
  } answer_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  logic [1:0]                      in_req_type = sovt_pkg::REQ_LOAD;
  logic [sovt_pkg::COORD_BITS-1:0] in_ax = '0;
  logic [sovt_pkg::COORD_BITS-1:0] in_ay = '0;
  logic [sovt_pkg::COORD_BITS-1:0] in_bx = '0;
  logic [sovt_pkg::COORD_BITS-1:0] in_by = '0;
  logic                            in_closes_polygon = 1'b0;
  logic                            out_valid;
  logic                            out_blocked;
  logic                            out_status;
  logic [sovt_pkg::CNT_BITS-1:0]   out_stored_vertices;

  word_t   pending_words[$];  // stimulus not yet shown to the block
  answer_t answers_due[$];    // predicted answers, oldest first
  word_t   shown;             // word currently on the in_ ports
  int      gap_left = 0;
  int      mismatches = 0;

  // Predictor state: vertex store, vertex count and start of the open polygon.
  sovt_pkg::vertex_t obstacle_pts [sovt_pkg::MAX_VERTICES];
  int                stored_count = 0;
  int                closed_end = 0;

  segment_obstacle_visibility_test uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_req_type        (in_req_type),
    .in_ax              (in_ax),
    .in_ay              (in_ay),
    .in_bx              (in_bx),
    .in_by              (in_by),
    .in_closes_polygon  (in_closes_polygon),
    .out_valid          (out_valid),
    .out_blocked        (out_blocked),
    .out_status         (out_status),
    .out_stored_vertices(out_stored_vertices)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------- predictor

  // Sign of (u - o) x (w - o). Coordinates are 9 bits, so products fit an int.
  function automatic int turn_sign(int ox, int oy, int ux, int uy, int wx, int wy);
    int v;
    v = (ux - ox) * (wy - oy) - (uy - oy) * (wx - ox);
    if (v > 0) return 1;
    if (v < 0) return -1;
    return 0;
  endfunction

  // Edge p-q blocks A-B on a proper crossing, or when p or q sits anywhere on
  // the infinite line through A and B (kept on purpose, even past the ends).
  function automatic bit edge_hits(int ax, int ay, int bx, int by, int p, int q);
    int px, py, qx, qy, sp, sq, sa, sb;
    px = int'(obstacle_pts[p].pt.x);
    py = int'(obstacle_pts[p].pt.y);
    qx = int'(obstacle_pts[q].pt.x);
    qy = int'(obstacle_pts[q].pt.y);
    sp = turn_sign(ax, ay, bx, by, px, py);
    sq = turn_sign(ax, ay, bx, by, qx, qy);
    sa = turn_sign(px, py, qx, qy, ax, ay);
    sb = turn_sign(px, py, qx, qy, bx, by);
    return ((sp * sq < 0) && (sa * sb < 0)) || sp == 0 || sq == 0;
  endfunction

  // Walks the closed polygons only; each one wraps from its last vertex to its
  // first, so a lone vertex gives an edge from itself to itself.
  function automatic bit sight_blocked(int ax, int ay, int bx, int by);
    int first, last, prev;
    first = 0;
    while (first < closed_end) begin
      last = first;
      while (last + 1 < closed_end && !obstacle_pts[last].closes) last++;
      prev = last;
      for (int i = first; i <= last; i++) begin
        if (edge_hits(ax, ay, bx, by, i, prev)) return 1'b1;
        prev = i;
      end
      first = last + 1;
    end
    return 1'b0;
  endfunction

  function automatic answer_t predict_answer(word_t w);
    answer_t a;
    a.blocked = 1'b0;
    a.status  = 1'b0;
    if (w.req == sovt_pkg::REQ_LOAD) begin
      if (stored_count >= sovt_pkg::MAX_VERTICES) begin
        a.status = 1'b1;  // store full: vertex dropped
      end else begin
        obstacle_pts[stored_count].pt.x   = w.ax;
        obstacle_pts[stored_count].pt.y   = w.ay;
        obstacle_pts[stored_count].closes = w.closes;
        stored_count++;
        if (w.closes) closed_end = stored_count;
      end
    end else if (w.req == sovt_pkg::REQ_CLEAR) begin
      stored_count = 0;
      closed_end   = 0;
    end else if (w.req == sovt_pkg::REQ_QUERY) begin
      a.blocked = sight_blocked(int'(w.ax), int'(w.ay), int'(w.bx), int'(w.by));
    end
    a.held = sovt_pkg::CNT_BITS'(stored_count);
    return a;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic queue_word(logic [1:0] req, int ax, int ay, int bx, int by,
                            bit closes, bit drain);
    word_t w;
    w.req    = req;
    w.ax     = sovt_pkg::COORD_BITS'(ax);
    w.ay     = sovt_pkg::COORD_BITS'(ay);
    w.bx     = sovt_pkg::COORD_BITS'(bx);
    w.by     = sovt_pkg::COORD_BITS'(by);
    w.closes = closes;
    w.drain  = drain;
    pending_words.push_back(w);
  endtask

  // Polygon of n vertices around (cx, cy); bx/by carry junk since loads ignore them.
  task automatic queue_polygon(int cx, int cy, int spread, int n, bit close_it);
    for (int i = 0; i < n; i++) begin
      queue_word(sovt_pkg::REQ_LOAD, (cx + $urandom_range(0, spread)) & COORD_MAX,
                 (cy + $urandom_range(0, spread)) & COORD_MAX,
                 $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                 close_it && (i == n - 1), 1'b0);
    end
  endtask

  // Query with a short, long or zero-length segment.
  task automatic queue_query(bit drain);
    int ax, ay, bx, by;
    ax = $urandom_range(0, COORD_MAX);
    ay = $urandom_range(0, COORD_MAX);
    case ($urandom_range(0, 5))
      0: begin
        bx = ax;
        by = ay;
      end
      1, 2: begin
        bx = (ax + $urandom_range(0, 60)) & COORD_MAX;
        by = (ay + $urandom_range(0, 60)) & COORD_MAX;
      end
      default: begin
        bx = $urandom_range(0, COORD_MAX);
        by = $urandom_range(0, COORD_MAX);
      end
    endcase
    queue_word(sovt_pkg::REQ_QUERY, ax, ay, bx, by, 1'($urandom_range(0, 1)), drain);
  endtask

  task automatic fill_stimulus();
    int left, n, scene, goal;

    // Directed: empty store, unknown code, square, crossings, collinear rule,
    // zero-length segment, lone vertex, open polygon ignored, clear.
    queue_word(sovt_pkg::REQ_QUERY, 0, 0, COORD_MAX, COORD_MAX, 1'b0, 1'b0);
    queue_word(REQ_UNKNOWN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b0);
    queue_word(sovt_pkg::REQ_LOAD, 100, 100, COORD_MAX, 0, 1'b0, 1'b0);
    queue_word(sovt_pkg::REQ_LOAD, 200, 100, 0, COORD_MAX, 1'b0, 1'b0);
    queue_word(sovt_pkg::REQ_LOAD, 200, 200, COORD_MAX, COORD_MAX, 1'b0, 1'b0);
    queue_word(sovt_pkg::REQ_LOAD, 100, 200, 0, 0, 1'b1, 1'b0);
    queue_word(sovt_pkg::REQ_QUERY, 0, 150, COORD_MAX, 150, 1'b0, 1'b0);   // crosses square
    queue_word(sovt_pkg::REQ_QUERY, 0, 0, 50, 50, 1'b0, 1'b0);             // line through corners
    queue_word(sovt_pkg::REQ_QUERY, 300, 20, COORD_MAX, 60, 1'b0, 1'b0);   // clear of it
    queue_word(sovt_pkg::REQ_QUERY, 5, 5, 5, 5, 1'b0, 1'b0);               // viewer on target
    queue_word(sovt_pkg::REQ_LOAD, COORD_MAX, 0, 0, 0, 1'b1, 1'b0);        // lone vertex
    queue_word(sovt_pkg::REQ_QUERY, COORD_MAX, COORD_MAX, COORD_MAX, 300, 1'b1, 1'b0);
    queue_word(sovt_pkg::REQ_LOAD, 300, 300, 0, 0, 1'b0, 1'b0);
    queue_word(sovt_pkg::REQ_LOAD, 310, 300, 0, 0, 1'b0, 1'b0);
    queue_word(sovt_pkg::REQ_QUERY, 290, 300, 320, 300, 1'b0, 1'b0);       // open, ignored
    queue_word(sovt_pkg::REQ_LOAD, 0, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b0);
    queue_word(sovt_pkg::REQ_QUERY, 290, 300, 320, 300, 1'b0, 1'b0);       // now closed
    queue_word(sovt_pkg::REQ_QUERY, 150, 50, 150, 100, 1'b0, 1'b0);        // ends on an edge
    queue_word(sovt_pkg::REQ_CLEAR, COORD_MAX, 0, COORD_MAX, 0, 1'b1, 1'b0);
    queue_word(sovt_pkg::REQ_QUERY, 0, 0, COORD_MAX, COORD_MAX, 1'b0, 1'b0);
    queue_word(sovt_pkg::REQ_LOAD, 0, 0, 0, 0, 1'b0, 1'b1);

    // Fill a quarter of the store, many lone vertices among short polygons, all
    // in the low corner, so queries in the far corner can still see past them.
    queue_word(sovt_pkg::REQ_CLEAR, 0, 0, 0, 0, 1'b0, 1'b1);
    left = sovt_pkg::MAX_VERTICES / 4;
    while (left > 0) begin
      n = $urandom_range(0, 1) ? 1 : $urandom_range(2, 8);
      if (n > left) n = left;
      queue_polygon(0, 0, 100, n, 1'b1);
      left -= n;
    end
    queue_word(sovt_pkg::REQ_QUERY, 300, 450, 500, 450, 1'b0, 1'b1);
    queue_word(sovt_pkg::REQ_QUERY, 50, 300, 60, 0, 1'b1, 1'b0);
    queue_query(1'b0);
    queue_query(1'b0);
    for (int i = 0; i < 3; i++) queue_polygon(200, 200, 300, 1, i[0]);  // far vertices: one closed pair, one left open
    queue_query(1'b0);
    queue_word(sovt_pkg::REQ_CLEAR, 0, 0, 0, 0, 1'b0, 1'b0);

    // Random scenes: mostly clear, a few polygons, then queries against them;
    // some scenes keep the old store, some leave a polygon open, some are noise.
    goal  = 580;
    scene = 0;
    while (pending_words.size() < goal) begin
      scene++;
      if ($urandom_range(0, 7) == 0) begin
        for (int i = 0; i < 4; i++) begin
          queue_word(2'($urandom_range(0, 3)), $urandom_range(0, COORD_MAX),
                     $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                     $urandom_range(0, COORD_MAX), 1'($urandom_range(0, 1)), 1'b0);
        end
      end else begin
        if ($urandom_range(0, 4) != 0) begin
          queue_word(sovt_pkg::REQ_CLEAR, $urandom_range(0, COORD_MAX),
                     $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                     $urandom_range(0, COORD_MAX), 1'($urandom_range(0, 1)),
                     scene % 10 == 0);
        end
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          queue_polygon($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                        $urandom_range(0, 1) ? 60 : COORD_MAX, $urandom_range(1, 6), 1'b1);
        end
        if ($urandom_range(0, 3) == 0) queue_polygon(0, 0, COORD_MAX, $urandom_range(1, 3), 1'b0);
        n = $urandom_range(2, 8);
        for (int i = 0; i < n; i++) queue_query(1'b0);
      end
    end
  endtask

  // ---------------------------------------------------------------- driver
  // Shows one word at a time; a word stays up until start && !busy takes it.
  // Idle gaps follow some accepted words, except near the end.
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) answers_due.push_back(predict_answer(shown));
      if (start && busy) begin
        // word still waiting for the block
      end else if (gap_left != 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_words.size() == 0 ||
                   (pending_words[0].drain && answers_due.size() != 0)) begin
        start <= 1'b0;
      end else if (start && pending_words.size() > 40 && $urandom_range(0, 3) == 0) begin
        start    <= 1'b0;
        gap_left <= $urandom_range(0, 6);
      end else begin
        shown = pending_words.pop_front();
        start             <= 1'b1;
        in_req_type       <= shown.req;
        in_ax             <= shown.ax;
        in_ay             <= shown.ay;
        in_bx             <= shown.bx;
        in_by             <= shown.by;
        in_closes_polygon <= shown.closes;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic note_fail(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // Each result word lives one cycle; sample it at the edge that ends that cycle.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid) begin
      if (answers_due.size() == 0) begin
        note_fail($sformatf("result word with none expected: blocked %0d status %0d held %0d",
                            out_blocked, out_status, out_stored_vertices));
      end else begin
        want = answers_due.pop_front();
        if (out_blocked !== want.blocked || out_status !== want.status ||
            out_stored_vertices !== want.held) begin
          note_fail($sformatf({"result word mismatch: blocked %0d/%0d status %0d/%0d ",
                               "held %0d/%0d (expected/actual)"},
                              want.blocked, out_blocked, want.status, out_status,
                              want.held, out_stored_vertices));
        end
      end
    end
  end

  // ---------------------------------------------------------------- end of run

  initial begin
    fill_stimulus();
    @(posedge clk);
    while (!rst_n || pending_words.size() != 0 || start) @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);  // catch any stray result word
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // A word costs at most a full-store walk plus the longest gap; this allows
  // several times that for every word of the run.
  initial begin
    #60000000;
    $display("Verification failed");
    $finish;
  end

endmodule
